FILE: rtl/mps_pkg.sv
// Package for the maze path search block: sizes, stack entry layout, status codes, FSM states, direction steps.
// No dependencies.
package mps_pkg;

    localparam int MAX_DIM     = 64;
    localparam int STACK_DEPTH = 64;
    localparam int ROW_W       = $clog2(MAX_DIM);
    localparam int CNT_W       = ROW_W + 1;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int TOP_W       = SP_W + 1;
    localparam int ENTRY_W     = 16;

    localparam logic [1:0] ST_NO_PATH  = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [ROW_W-1:0] START_POS = ROW_W'(1);

    typedef struct packed {
        logic [5:0] row;
        logic [5:0] col;
        logic [3:0] dir;
    } entry_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_INIT,
        S_POP_RD,
        S_PROBE_RD,
        S_EVAL,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_STATUS
    } state_t;

    // row step per direction N, NE, E, SE, S, SW, W, NW
    function automatic logic [1:0] dir_dr(input logic [2:0] d);
        logic [1:0] r;
        unique case (d)
            3'd0, 3'd1, 3'd7: r = 2'b11;
            3'd3, 3'd4, 3'd5: r = 2'b01;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] dir_dc(input logic [2:0] d);
        logic [1:0] r;
        unique case (d)
            3'd1, 3'd2, 3'd3: r = 2'b01;
            3'd5, 3'd6, 3'd7: r = 2'b11;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/mps_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module mps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/maze_path_search_dfs.sv
// Maze path search (depth-first, 8 directions): rows load at one per cycle while busy is low.
// The row flagged last_row raises busy; below three rows a status result follows, else the
// search clears the mark memory (one row a cycle), pushes the start cell, steps each probe
// through top read, wall and mark probe reads, and evaluate and write back, and each pop through
// top read and entry read, then streams one result per loaded row, or a single status result.
// Results carry a one-cycle strobe and cannot be held off. Depends on mps_pkg and mps_ram.
module maze_path_search_dfs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [63:0]              row_walls,
    input  logic                     last_row,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic [5:0]               row_index,
    output logic [63:0]              visited_bits,
    output logic                     last_result
);
    import mps_pkg::*;

    state_t state_reg, state_next;

    logic [6:0]       cols_reg;
    logic [CNT_W-1:0] rows_reg, rows_next;
    logic [CNT_W-1:0] nrows_reg, nrows_next;
    logic [TOP_W-1:0] top_reg, top_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;
    entry_t           cur_reg, cur_next;
    logic [5:0]       nr_reg, nr_next, nc_reg, nc_next;
    logic             inb_reg, inb_next;
    logic [1:0]       st_reg, st_next;

    logic             out_v_reg, out_v_next;
    logic [1:0]       out_st_reg, out_st_next;
    logic [5:0]       out_row_reg, out_row_next;
    logic [63:0]      out_bits_reg, out_bits_next;
    logic             out_last_reg, out_last_next;

    // memory ports
    logic               wall_we;
    logic [ROW_W-1:0]   wall_wa, wall_ra;
    logic [63:0]        wall_rd;
    logic               vis_we;
    logic [ROW_W-1:0]   vis_wa, vis_ra;
    logic [63:0]        vis_wd, vis_rd;
    logic               stk_we;
    logic [SP_W-1:0]    stk_wa, stk_ra;
    logic [ENTRY_W-1:0] stk_wd, stk_rd;

    mps_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_wall (
        .clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(row_walls),
        .raddr(wall_ra), .rdata(wall_rd));
    mps_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_visit (
        .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
        .raddr(vis_ra), .rdata(vis_rd));
    mps_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .raddr(stk_ra), .rdata(stk_rd));

    logic accept;
    assign accept = start && !busy;

    // clamped column count and goal
    logic [6:0] ncols;
    always_comb
    begin
        if (cols_reg < 7'd3)
            ncols = 7'd3;
        else if (cols_reg > 7'(MAX_DIM))
            ncols = 7'(MAX_DIM);
        else
            ncols = cols_reg;
    end

    logic [6:0] goal_c;
    logic [CNT_W-1:0] goal_r;
    assign goal_c = ncols - 7'd2;
    assign goal_r = nrows_reg - CNT_W'(2);

    // neighbor of the entry read from the stack; drives the probe reads in PROBE_RD
    entry_t           probe_e;
    logic [1:0]       p_dr, p_dc;
    logic [6:0]       pnr, pnc;
    logic             pinb;
    logic [ROW_W-1:0] probe_ra;
    always_comb
    begin
        probe_e = entry_t'(stk_rd);
        p_dr    = dir_dr(probe_e.dir[2:0]);
        p_dc    = dir_dc(probe_e.dir[2:0]);
        pnr     = {1'b0, probe_e.row} + {{5{p_dr[1]}}, p_dr};
        pnc     = {1'b0, probe_e.col} + {{5{p_dc[1]}}, p_dc};
        pinb    = !pnr[6] && !pnc[6] && (CNT_W'(pnr) < nrows_reg) && (pnc < ncols);
    end
    assign probe_ra = pnr[ROW_W-1:0];

    logic open_w, marked_w, goal_w;
    assign open_w   = inb_reg && !wall_rd[nc_reg];
    assign marked_w = vis_rd[nc_reg];
    assign goal_w   = (CNT_W'(nr_reg) == goal_r) && ({1'b0, nc_reg} == goal_c);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && last_row)
                begin
                    if (((rows_reg < CNT_W'(MAX_DIM)) ? rows_reg + CNT_W'(1) : rows_reg)
                        < CNT_W'(3))
                        state_next = S_STATUS;
                    else
                        state_next = S_CLEAR;
                end
            end
            S_CLEAR:
                if (cnt_reg == ROW_W'(MAX_DIM - 1))
                    state_next = S_INIT;
            S_INIT:     state_next = S_POP_RD;
            S_POP_RD:
                if (top_reg == '0)
                    state_next = S_STATUS;
                else
                    state_next = S_PROBE_RD;
            S_PROBE_RD:
                if (probe_e.dir[3])
                    state_next = S_POP_RD;
                else
                    state_next = S_EVAL;
            S_EVAL:
            begin
                if (open_w && !marked_w && top_reg >= TOP_W'(STACK_DEPTH))
                    state_next = S_STATUS;
                else if (open_w && goal_w)
                    state_next = S_DUMP_RD;
                else
                    state_next = S_POP_RD;
            end
            S_DUMP_RD:  state_next = S_DUMP_OUT;
            S_DUMP_OUT:
                if (CNT_W'(cnt_reg) == nrows_reg - CNT_W'(1))
                    state_next = S_LOAD;
                else
                    state_next = S_DUMP_RD;
            S_STATUS:   state_next = S_LOAD;
            default:    state_next = S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        rows_next     = rows_reg;
        nrows_next    = nrows_reg;
        top_next      = top_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        nr_next       = nr_reg;
        nc_next       = nc_reg;
        inb_next      = inb_reg;
        st_next       = st_reg;
        out_v_next    = 1'b0;
        out_st_next   = out_st_reg;
        out_row_next  = out_row_reg;
        out_bits_next = out_bits_reg;
        out_last_next = out_last_reg;
        wall_we = 1'b0;
        wall_wa = rows_reg[ROW_W-1:0];
        wall_ra = probe_ra;
        vis_we  = 1'b0;
        vis_wa  = cnt_reg;
        vis_wd  = '0;
        vis_ra  = probe_ra;
        stk_we  = 1'b0;
        stk_wa  = top_reg[SP_W-1:0];
        stk_wd  = '0;
        stk_ra  = SP_W'(top_reg - TOP_W'(1));
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (rows_reg < CNT_W'(MAX_DIM))
                    begin
                        wall_we   = 1'b1;
                        rows_next = rows_reg + CNT_W'(1);
                    end
                    if (last_row)
                    begin
                        nrows_next = (rows_reg < CNT_W'(MAX_DIM)) ?
                                     rows_reg + CNT_W'(1) : rows_reg;
                        rows_next  = '0;
                        cnt_next   = '0;
                        st_next    = ST_NO_PATH;
                    end
                end
            end
            S_CLEAR:
            begin
                vis_we   = 1'b1;
                vis_wa   = cnt_reg;
                cnt_next = cnt_reg + ROW_W'(1);
            end
            S_INIT:
            begin
                // start cell always marked and pushed
                vis_we   = 1'b1;
                vis_wa   = START_POS;
                vis_wd   = 64'd1 << 1;
                stk_we   = 1'b1;
                stk_wa   = '0;
                stk_wd   = {6'd1, 6'd1, 4'd0};
                top_next = TOP_W'(1);
            end
            S_POP_RD:
            begin
                // stack read issued (raddr = top-1)
            end
            S_PROBE_RD:
            begin
                cur_next = entry_t'(stk_rd);
                if (cur_next.dir[3])
                    top_next = top_reg - TOP_W'(1);
                else
                begin
                    stk_we = 1'b1;
                    stk_wa = SP_W'(top_reg - TOP_W'(1));
                    stk_wd = {cur_next.row, cur_next.col, cur_next.dir + 4'd1};
                end
            end
            S_EVAL:
            begin
                if (open_w && !marked_w)
                begin
                    if (top_reg >= TOP_W'(STACK_DEPTH))
                        st_next = ST_OVERFLOW;
                    else
                    begin
                        vis_we   = 1'b1;
                        vis_wa   = nr_reg[ROW_W-1:0];
                        vis_wd   = vis_rd | (64'd1 << nc_reg);
                        stk_we   = 1'b1;
                        stk_wa   = top_reg[SP_W-1:0];
                        stk_wd   = {nr_reg, nc_reg, 4'd0};
                        top_next = top_reg + TOP_W'(1);
                    end
                end
                if (open_w && goal_w && !(open_w && !marked_w
                    && top_reg >= TOP_W'(STACK_DEPTH)))
                begin
                    st_next  = ST_FOUND;
                    cnt_next = '0;
                end
            end
            S_DUMP_RD:
            begin
                vis_ra = cnt_reg;
            end
            S_DUMP_OUT:
            begin
                out_v_next    = 1'b1;
                out_st_next   = ST_FOUND;
                out_row_next  = 6'(cnt_reg);
                out_bits_next = vis_rd;
                out_last_next = (CNT_W'(cnt_reg) == nrows_reg - CNT_W'(1));
                cnt_next      = cnt_reg + ROW_W'(1);
            end
            S_STATUS:
            begin
                out_v_next    = 1'b1;
                out_st_next   = st_reg;
                out_row_next  = '0;
                out_bits_next = '0;
                out_last_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cols_reg  <= 7'd64;
            rows_reg  <= '0;
            top_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            top_reg   <= top_next;
            out_v_reg <= out_v_next;
            if (psel && penable && pwrite && paddr == 2'd0)
                cols_reg <= pwdata[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        nrows_reg    <= nrows_next;
        cnt_reg      <= cnt_next;
        cur_reg      <= cur_next;
        st_reg       <= st_next;
        out_st_reg   <= out_st_next;
        out_row_reg  <= out_row_next;
        out_bits_reg <= out_bits_next;
        out_last_reg <= out_last_next;
        if (state_reg == S_PROBE_RD)
        begin
            nr_reg  <= pnr[5:0];
            nc_reg  <= pnc[5:0];
            inb_reg <= pinb;
        end
        else
        begin
            nr_reg  <= nr_next;
            nc_reg  <= nc_next;
            inb_reg <= inb_next;
        end
    end

    assign busy         = (state_reg != S_LOAD) || out_v_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr == 2'd0) ? {25'd0, cols_reg} : 32'd0;
    assign strobe       = out_v_reg;
    assign status       = out_st_reg;
    assign row_index    = out_row_reg;
    assign visited_bits = out_bits_reg;
    assign last_result  = out_last_reg;

endmodule

FILE: rtl/mps_checker.sv
// Port-level checker for maze_path_search_dfs, bound to the top level.
// Depends on the top level's ports only.
module mps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       busy,
    input logic       strobe,
    input logic [1:0] status,
    input logic [5:0] row_index,
    input logic       last_result
);

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy) else $error("strobe while not busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (status != 2'd3)) else $error("bad status");

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != 2'd1 |-> last_result && row_index == 6'd0)
        else $error("status result not single");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_result |=> !strobe) else $error("result after last");

    a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_result |=> !strobe) else $error("rows too close");

endmodule

bind maze_path_search_dfs mps_checker u_mps_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .strobe(strobe),
    .status(status), .row_index(row_index), .last_result(last_result));
